/* rtl/core/wct_pkg.sv */
// Shared types and codes for the wait channel table.
// Beat structs for both channels, command and status codes, default sizes.
// No dependencies.
package wct_pkg;

  localparam int DEF_CHANNELS     = 256;
  localparam int DEF_ADDRESS_BITS = 48;
  localparam int DEF_OWNER_BITS   = 16;

  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] CMD_ENTER  = 2'd0;
  localparam logic [1:0] CMD_LEAVE  = 2'd1;
  localparam logic [1:0] CMD_WAKE   = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_CHANGED    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_TIMED_OUT  = 3'd3;
  localparam logic [2:0] ST_NO_CANCEL  = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        owner_id;
    logic [47:0]        word_address;
    logic signed [31:0] current_value;
    logic signed [31:0] expected_value;
    logic [7:0]         slot_index;
    logic [63:0]        deadline_tick;
    logic [63:0]        now_tick;
  } wct_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  found_slot;
    logic [15:0] waiter_total;
    logic        wake_request;
  } wct_out_t;

  typedef struct packed {
    logic hit;
    logic free_vld;
  } wct_flags_t;

endpackage

/* rtl/core/wait_channel_table.sv */
// Wait channel table top level: sequencer, result register, channel RAM.
// Uses wct_pkg, wct_ram and wct_resp.
//
// One command is in work at a time. Enter-wait and wake scan the channel RAM one
// entry per cycle with the compare in the cycle after the read, and a scan stops
// early when the key hits; enter-wait with a changed value skips the scan;
// leave-wait and cancel read one entry, or none when slot_index lies outside the
// table. The single read port of the RAM sets the scan length. After reset the
// block clears the RAM, one entry a cycle, with in_stall high until all entries
// are cleared. A finished result waits in the output register while the next
// command is already accepted.
module wait_channel_table import wct_pkg::*; #(
  parameter int CHANNELS     = DEF_CHANNELS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  parameter int OWNER_BITS   = DEF_OWNER_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wct_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wct_out_t out_data
);

  localparam int IDX_W = $clog2(CHANNELS);
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int ENT_W = OWNER_BITS + ADDRESS_BITS + COUNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  wct_in_t          beat_r, beat_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [ENT_W-1:0] hit_ent_r, hit_ent_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  wct_out_t         out_data_r, out_data_nxt;

  logic             in_acc;
  logic             load;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             rd_live;
  logic             rd_match;
  logic             in_slot_ok;

  wct_flags_t       flags;
  wct_out_t         resp;
  logic             resp_wr;
  logic [IDX_W-1:0] resp_addr;
  logic [ENT_W-1:0] resp_data;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign load       = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign in_slot_ok = (32'(in_data.slot_index) < CHANNELS);

  assign rd_live  = (rd_data[COUNT_W-1:0] != '0);
  assign rd_match = rd_live && (rd_data[ENT_W-1:COUNT_W] ==
                    {OWNER_BITS'(beat_r.owner_id), ADDRESS_BITS'(beat_r.word_address)});

  assign flags.hit      = hit_r;
  assign flags.free_vld = free_vld_r;

  always_comb begin
    state_nxt     = state_r;
    beat_nxt      = beat_r;
    clr_cnt_nxt   = clr_cnt_r;
    iss_cnt_nxt   = iss_cnt_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    rd_en         = 1'b0;
    rd_addr       = hit_idx_r;
    wr_en         = 1'b0;
    wr_addr       = resp_addr;
    wr_data       = resp_data;
    unique case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(CHANNELS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          beat_nxt     = in_data;
          hit_nxt      = 1'b0;
          free_vld_nxt = 1'b0;
          iss_cnt_nxt  = '0;
          hit_idx_nxt  = IDX_W'(in_data.slot_index);
          case (in_data.cmd) inside
            CMD_ENTER: begin
              state_nxt = (in_data.current_value == in_data.expected_value) ? S_SCAN : S_FIN;
            end
            CMD_WAKE: begin
              state_nxt = S_SCAN;
            end
            CMD_LEAVE, CMD_CANCEL: begin
              state_nxt = in_slot_ok ? S_READ : S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (iss_cnt_r < CNT_W'(CHANNELS)) begin
          rd_en       = 1'b1;
          rd_addr     = iss_cnt_r[IDX_W-1:0];
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_cnt_r[IDX_W-1:0];
        end
        if (cmp_vld_r) begin
          if (rd_match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            hit_ent_nxt = rd_data;
            state_nxt   = S_FIN;
          end else begin
            if (!rd_live && !free_vld_r) begin
              free_vld_nxt = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
            if (cmp_idx_r == IDX_W'(CHANNELS - 1)) begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        rd_addr   = hit_idx_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        hit_nxt     = rd_live;
        hit_ent_nxt = rd_data;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (load) begin
          wr_en     = resp_wr;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = resp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r     <= beat_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    free_vld_r <= free_vld_nxt;
    free_idx_r <= free_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  wct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wct_resp #(
    .CHANNELS     (CHANNELS),
    .ADDRESS_BITS (ADDRESS_BITS),
    .OWNER_BITS   (OWNER_BITS)
  ) u_resp (
    .beat     (beat_r),
    .flags    (flags),
    .hit_idx  (hit_idx_r),
    .hit_ent  (hit_ent_r),
    .free_idx (free_idx_r),
    .result   (resp),
    .wr_req   (resp_wr),
    .wr_addr  (resp_addr),
    .wr_data  (resp_data)
  );

  a_no_write_mid_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_READ || state_r == S_LOAD) |-> !wr_en)
    else $error("channel RAM written while an entry is in work");

  a_wake_has_waiters: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.wake_request) |-> (out_data.waiter_total != '0))
    else $error("wake request raised on an empty channel");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && state_r != S_FIN) |=> !out_valid)
    else $error("result beat delivered twice");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && hit_r &&
     (beat_r.cmd == CMD_LEAVE || beat_r.cmd == CMD_CANCEL))
    |-> (32'(beat_r.slot_index) < CHANNELS))
    else $error("live channel reported for a slot outside the table");

endmodule

/* rtl/core/wct_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module wct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/wct_resp.sv */
// Result and write-back decision for one command of the wait channel table.
// Works from the held input beat and the scan or read outcome; uses wct_pkg.
module wct_resp import wct_pkg::*; #(
  parameter int CHANNELS     = DEF_CHANNELS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  parameter int OWNER_BITS   = DEF_OWNER_BITS
) (
  input  wct_in_t                                      beat,
  input  wct_flags_t                                   flags,
  input  logic [$clog2(CHANNELS)-1:0]                  hit_idx,
  input  logic [OWNER_BITS+ADDRESS_BITS+COUNT_W-1:0]   hit_ent,
  input  logic [$clog2(CHANNELS)-1:0]                  free_idx,
  output wct_out_t                                     result,
  output logic                                         wr_req,
  output logic [$clog2(CHANNELS)-1:0]                  wr_addr,
  output logic [OWNER_BITS+ADDRESS_BITS+COUNT_W-1:0]   wr_data
);

  localparam int ENT_W = OWNER_BITS + ADDRESS_BITS + COUNT_W;

  logic [OWNER_BITS-1:0]   owner_k;
  logic [ADDRESS_BITS-1:0] addr_k;
  logic [COUNT_W-1:0]      hit_cnt;
  logic [COUNT_W-1:0]      dec_cnt;
  logic [COUNT_W-1:0]      inc_cnt;
  logic [ENT_W-1:0]        dec_ent;
  logic                    value_eq;
  logic                    timed_out;

  assign owner_k   = OWNER_BITS'(beat.owner_id);
  assign addr_k    = ADDRESS_BITS'(beat.word_address);
  assign hit_cnt   = hit_ent[COUNT_W-1:0];
  assign dec_cnt   = hit_cnt - COUNT_W'(1);
  assign inc_cnt   = hit_cnt + COUNT_W'(1);
  assign dec_ent   = (dec_cnt == '0) ? '0 : {hit_ent[ENT_W-1:COUNT_W], dec_cnt};
  assign value_eq  = (beat.current_value == beat.expected_value);
  assign timed_out = (beat.deadline_tick != '0) && (beat.now_tick >= beat.deadline_tick)
                     && value_eq;

  always_comb begin
    result  = '0;
    wr_req  = 1'b0;
    wr_addr = hit_idx;
    wr_data = dec_ent;
    case (beat.cmd)
      CMD_ENTER: begin
        if (!value_eq) begin
          result.status = ST_CHANGED;
        end else if (flags.hit) begin
          result.found_slot = SLOT_W'(hit_idx);
          if (hit_cnt == COUNT_MAX) begin
            result.status = ST_FULL;
          end else begin
            wr_req  = 1'b1;
            wr_data = {owner_k, addr_k, inc_cnt};
          end
        end else if (flags.free_vld) begin
          result.found_slot = SLOT_W'(free_idx);
          wr_req  = 1'b1;
          wr_addr = free_idx;
          wr_data = {owner_k, addr_k, COUNT_W'(1)};
        end else begin
          result.status = ST_FULL;
        end
      end
      CMD_LEAVE: begin
        result.found_slot = beat.slot_index;
        wr_req = flags.hit;
        if (timed_out) begin
          result.status = ST_TIMED_OUT;
        end
      end
      CMD_WAKE: begin
        if (flags.hit) begin
          result.found_slot   = SLOT_W'(hit_idx);
          result.waiter_total = hit_cnt;
          result.wake_request = 1'b1;
        end
      end
      default: begin
        result.found_slot = beat.slot_index;
        wr_req = flags.hit;
        if (!flags.hit) begin
          result.status = ST_NO_CANCEL;
        end
      end
    endcase
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench for wait_channel_table: directed, table-full, back-pressure and random traffic.
// Keeps its own copy of the channel table to predict every reply. Needs wct_pkg and the RTL.
module tb;
  import wct_pkg::*;

  localparam int CHANNELS    = DEF_CHANNELS;
  localparam int KEYS        = 10;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  wct_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  wct_out_t out_data;

  logic [15:0] chan_owner   [CHANNELS];
  logic [47:0] chan_addr    [CHANNELS];
  logic [15:0] chan_waiters [CHANNELS];
  logic [15:0] key_owner    [KEYS];
  logic [47:0] key_addr     [KEYS];

  wct_out_t reply_q [$];
  wct_out_t want_reply;
  int       send_gap_pct = 0;
  int       recv_gap_pct = 0;
  int       hold_request = 0;
  int       hold_left = 0;
  int       errors = 0;
  int       sent_count = 0;
  int       checked_count = 0;
  int       cycle_count = 0;

  wait_channel_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d replies outstanding", cycle_count,
               reply_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic void seek_channel(input logic [15:0] owner, input logic [47:0] addr,
                                       output int hit, output int free_at);
    int i;
    hit = -1;
    free_at = -1;
    for (i = 0; i < CHANNELS; i++) begin
      if (chan_waiters[i] != '0) begin
        if (chan_owner[i] == owner && chan_addr[i] == addr) begin
          hit = i;
          return;
        end
      end else if (free_at < 0) begin
        free_at = i;
      end
    end
  endfunction

  function automatic bit drop_waiter(input logic [7:0] slot);
    if (int'(slot) >= CHANNELS || chan_waiters[slot] == '0) return 1'b0;
    chan_waiters[slot] = chan_waiters[slot] - 16'd1;
    if (chan_waiters[slot] == '0) begin
      chan_owner[slot] = '0;
      chan_addr[slot] = '0;
    end
    return 1'b1;
  endfunction

  function automatic wct_out_t apply_command(input wct_in_t c);
    wct_out_t r;
    int hit, free_at;
    r = '0;
    case (c.cmd)
      CMD_ENTER: begin
        if (c.current_value != c.expected_value) begin
          r.status = ST_CHANGED;
        end else begin
          seek_channel(c.owner_id, c.word_address, hit, free_at);
          if (hit < 0 && free_at >= 0) begin
            hit = free_at;
            chan_owner[hit] = c.owner_id;
            chan_addr[hit] = c.word_address;
          end
          if (hit < 0) begin
            r.status = ST_FULL;
          end else begin
            r.found_slot = hit[7:0];
            if (chan_waiters[hit] == COUNT_MAX) r.status = ST_FULL;
            else chan_waiters[hit] = chan_waiters[hit] + 16'd1;
          end
        end
      end
      CMD_LEAVE: begin
        r.found_slot = c.slot_index;
        void'(drop_waiter(c.slot_index));
        if (c.deadline_tick != '0 && c.now_tick >= c.deadline_tick &&
            c.current_value == c.expected_value) r.status = ST_TIMED_OUT;
      end
      CMD_WAKE: begin
        seek_channel(c.owner_id, c.word_address, hit, free_at);
        if (hit >= 0) begin
          r.found_slot = hit[7:0];
          r.waiter_total = chan_waiters[hit];
          r.wake_request = 1'b1;
        end
      end
      default: begin
        r.found_slot = c.slot_index;
        if (!drop_waiter(c.slot_index)) r.status = ST_NO_CANCEL;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] slot_of(input int k);
    int hit, free_at;
    seek_channel(key_owner[k], key_addr[k], hit, free_at);
    return hit[7:0];
  endfunction

  function automatic int pick_live_slot();
    int live [$];
    int i;
    for (i = 0; i < CHANNELS; i++)
      if (chan_waiters[i] != '0) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic wct_in_t noise_beat();
    wct_in_t b;
    logic [31:0] r;
    r = $urandom;
    b.cmd = r[1:0];
    b.slot_index = r[15:8];
    b.owner_id = r[31:16];
    r = $urandom;
    b.word_address = {r[15:0], $urandom};
    b.current_value = $urandom;
    b.expected_value = $urandom;
    b.deadline_tick = {$urandom, $urandom};
    b.now_tick = {$urandom, $urandom};
    return b;
  endfunction

  function automatic wct_in_t keyed_beat(input logic [1:0] cmd, input int k);
    wct_in_t b;
    b = noise_beat();
    b.cmd = cmd;
    b.owner_id = key_owner[k];
    b.word_address = key_addr[k];
    b.expected_value = b.current_value;
    return b;
  endfunction

  function automatic wct_in_t release_beat(input int slot);
    wct_in_t b;
    b = noise_beat();
    b.cmd = ($urandom_range(1) == 0) ? CMD_LEAVE : CMD_CANCEL;
    if (slot >= 0) b.slot_index = slot[7:0];
    if ($urandom_range(4) != 0) b.expected_value = b.current_value;
    case ($urandom_range(3))
      0: b.deadline_tick = '0;
      1: b.now_tick = b.deadline_tick;
      2: b.now_tick = b.deadline_tick - 64'd1;
      default: ;
    endcase
    return b;
  endfunction

  function automatic wct_in_t traffic_beat();
    wct_in_t b;
    int pick, k;
    pick = $urandom_range(99);
    k = $urandom_range(KEYS - 1);
    if (pick < 12) begin
      b = noise_beat();
    end else if (pick < 50) begin
      b = keyed_beat(CMD_ENTER, k);
      if ($urandom_range(9) == 0) b.expected_value = ~b.current_value;
    end else if (pick < 72) begin
      b = keyed_beat(CMD_WAKE, k);
    end else begin
      b = release_beat(pick_live_slot());
    end
    return b;
  endfunction

  task automatic send_beat(input wct_in_t beat);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    reply_q.push_back(apply_command(beat));
    sent_count++;
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: reply beat with none pending, expected nothing, got %h", $time,
                 out_data);
      end else begin
        want_reply = reply_q.pop_front();
        checked_count++;
        check_field("status", 16'(want_reply.status), 16'(out_data.status));
        check_field("found_slot", 16'(want_reply.found_slot), 16'(out_data.found_slot));
        check_field("waiter_total", want_reply.waiter_total, out_data.waiter_total);
        check_field("wake_request", 16'(want_reply.wake_request),
                    16'(out_data.wake_request));
      end
    end
  end

  task automatic test_basic_commands();
    wct_in_t b;
    logic [7:0] s;
    int k;
    send_beat(keyed_beat(CMD_WAKE, 1));
    b = noise_beat();
    b.cmd = CMD_CANCEL;
    send_beat(b);
    b = noise_beat();
    b.cmd = CMD_LEAVE;
    b.slot_index = '1;
    b.deadline_tick = '0;
    b.now_tick = '1;
    send_beat(b);
    b = keyed_beat(CMD_ENTER, 0);
    b.current_value = 32'h8000_0000;
    b.expected_value = 32'h7fff_ffff;
    send_beat(b);
    for (k = 0; k < 4; k++) send_beat(keyed_beat(CMD_ENTER, k));
    b = keyed_beat(CMD_ENTER, 0);
    b.current_value = '1;
    b.expected_value = '1;
    send_beat(b);
    b.current_value = 32'h8000_0000;
    b.expected_value = 32'h8000_0000;
    send_beat(b);
    send_beat(keyed_beat(CMD_WAKE, 0));
    send_beat(keyed_beat(CMD_WAKE, 2));
    s = slot_of(0);
    b = keyed_beat(CMD_LEAVE, 0);
    b.slot_index = s;
    b.deadline_tick = '1;
    b.now_tick = '1;
    send_beat(b);
    b.deadline_tick = 64'd5;
    b.now_tick = 64'd4;
    send_beat(b);
    b.deadline_tick = 64'd1;
    b.now_tick = '1;
    b.expected_value = ~b.current_value;
    send_beat(b);
    send_beat(keyed_beat(CMD_WAKE, 0));
    s = slot_of(1);
    b = keyed_beat(CMD_CANCEL, 1);
    b.slot_index = s;
    send_beat(b);
    send_beat(b);
    b = keyed_beat(CMD_LEAVE, 2);
    b.slot_index = slot_of(2);
    b.deadline_tick = '0;
    send_beat(b);
    b = keyed_beat(CMD_CANCEL, 3);
    b.slot_index = slot_of(3);
    send_beat(b);
  endtask

  task automatic test_table_full();
    wct_in_t b, probe;
    int hit, free_at, s;
    forever begin
      b = noise_beat();
      b.cmd = CMD_ENTER;
      b.expected_value = b.current_value;
      seek_channel(b.owner_id, b.word_address, hit, free_at);
      if (hit < 0 && free_at < 0) break;
      send_beat(b);
    end
    send_beat(b);
    s = pick_live_slot();
    probe = b;
    probe.owner_id = chan_owner[s];
    probe.word_address = chan_addr[s];
    send_beat(probe);
    probe.cmd = CMD_WAKE;
    send_beat(probe);
    b.expected_value = ~b.current_value;
    send_beat(b);
    s = pick_live_slot();
    while (s >= 0) begin
      send_beat(release_beat(s));
      s = pick_live_slot();
    end
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_beat(traffic_beat());
  endtask

  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(negedge clk);
    hold_request = 500;
    @(posedge clk);
    repeat (12) send_beat(release_beat(pick_live_slot()));
  endtask

  task automatic test_pause_until_drained();
    repeat (6) send_beat(traffic_beat());
    wait_all_replies();
    repeat (6) send_beat(traffic_beat());
  endtask

  initial begin
    int i;
    logic [31:0] r;
    for (i = 0; i < CHANNELS; i++) begin
      chan_owner[i] = '0;
      chan_addr[i] = '0;
      chan_waiters[i] = '0;
    end
    key_owner[0] = '1;
    key_addr[0] = '1;
    key_owner[1] = '0;
    key_addr[1] = '0;
    key_owner[2] = '1;
    key_addr[2] = '0;
    key_owner[3] = '0;
    key_addr[3] = '1;
    for (i = 4; i < KEYS; i++) begin
      r = $urandom;
      key_owner[i] = r[15:0];
      key_addr[i] = {r[31:16], $urandom};
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 38;
    recv_gap_pct = 57;
    test_basic_commands();
    test_table_full();

    send_gap_pct = 57;
    recv_gap_pct = 38;
    test_random_traffic(200);
    test_backpressure();
    test_pause_until_drained();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(200);

    wait_all_replies();
    repeat (CHANNELS + 8) @(posedge clk);
    $display("tb: %0d commands sent, %0d replies checked", sent_count, checked_count);
    $display("tb: covered each command, a full table, timeouts and back-pressure");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
